[rtl/sha256_byte_stream_hasher_defines.svh]
// assertion macros shared by the hasher rtl
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SBSH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/sbsh_pkg.sv]
// types, constants and round functions for the sha-256 byte stream hasher
package sbsh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMPRESS,
        ST_ADD,
        ST_OUT
    } state_t;

    localparam int unsigned ROUNDS       = 64;
    localparam int unsigned CHAIN_WORDS  = 8;
    localparam int unsigned WINDOW_WORDS = 16;
    localparam logic [7:0]  PAD_MARK     = 8'h80;
    localparam logic [5:0]  LEN_START    = 6'd56;
    localparam logic [5:0]  BLOCK_LAST   = 6'd63;
    localparam logic [5:0]  ROUND_LAST   = 6'd63;
    localparam logic [2:0]  WORD_LAST    = 3'd7;

    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] v);
        big_sigma0 = {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] v);
        big_sigma1 = {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] v);
        small_sigma0 = {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] v);
        small_sigma1 = {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
    endfunction

endpackage

[rtl/sha256_byte_stream_hasher.sv]
// a byte item that fills a block starts a compression: 64 rounds, then the chain add
// a last item pads one byte per cycle and runs one or two more compressions
// the digest leaves as eight words, one per accepted output transaction, then ready returns
// throughput is set by the single round unit: one round per cycle, 64 per 64-byte block
// rst_n clears the sequencer and loads the initial hash; the schedule window has no reset
module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        no_byte,
    input  logic        is_last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        final_word
);
    import sbsh_pkg::*;
    `include "sha256_byte_stream_hasher_defines.svh"

    state_t      state_reg, state_next;
    logic [31:0] chain_reg  [0:7];
    logic [31:0] chain_next [0:7];
    logic [31:0] round_reg  [0:7];
    logic [31:0] round_next [0:7];
    logic [31:0] win_reg    [0:15];
    logic [31:0] win_next   [0:15];
    logic [23:0] acc_reg, acc_next;
    logic [63:0] len_reg, len_next;
    logic [5:0]  fill_reg, fill_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [2:0]  out_cnt_reg, out_cnt_next;
    logic        pad_active_reg, pad_active_next;
    logic        mark_done_reg, mark_done_next;
    logic        len_phase_reg, len_phase_next;

    logic        in_fire, out_fire;
    logic        put_en, block_done;
    logic [7:0]  put_data, pad_data;
    logic        pad_is_len;
    logic [31:0] t1, t2, sched_new;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // padding byte source: marker, zeros, then the bit length big-endian
    assign pad_is_len = mark_done_reg && (len_phase_reg || (fill_reg == LEN_START));
    always_comb
    begin
        if (!mark_done_reg)
        begin
            pad_data = PAD_MARK;
        end
        else if (pad_is_len)
        begin
            pad_data = len_reg[8 * (7 - fill_reg[2:0]) +: 8];
        end
        else
        begin
            pad_data = 8'h00;
        end
    end

    assign put_en     = (in_fire && !no_byte) || (state_reg == ST_PAD);
    assign put_data   = (state_reg == ST_PAD) ? pad_data : data_byte;
    assign block_done = put_en && (fill_reg == BLOCK_LAST);

    // shared round unit
    assign t1 = round_reg[7] + big_sigma1(round_reg[4])
              + ((round_reg[4] & round_reg[5]) ^ (~round_reg[4] & round_reg[6]))
              + ROUND_K[rnd_reg] + win_reg[0];
    assign t2 = big_sigma0(round_reg[0])
              + ((round_reg[0] & round_reg[1]) ^ (round_reg[0] & round_reg[2])
                 ^ (round_reg[1] & round_reg[2]));
    assign sched_new = small_sigma1(win_reg[14]) + win_reg[9]
                     + small_sigma0(win_reg[1]) + win_reg[0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (block_done)
                    begin
                        state_next = ST_COMPRESS;
                    end
                    else if (is_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                if (block_done)
                begin
                    state_next = ST_COMPRESS;
                end
            end
            ST_COMPRESS:
            begin
                if (rnd_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                if (len_phase_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_fire && (out_cnt_reg == WORD_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
                in_ready  = 1'b0;
                out_valid = 1'b0;
            end
        endcase
    end

    assign digest_word = chain_reg[0];
    assign word_index  = out_cnt_reg;
    assign final_word  = (out_cnt_reg == WORD_LAST);

    // datapath next values
    always_comb
    begin
        chain_next      = chain_reg;
        round_next      = round_reg;
        win_next        = win_reg;
        acc_next        = acc_reg;
        len_next        = len_reg;
        fill_next       = fill_reg;
        rnd_next        = rnd_reg;
        out_cnt_next    = out_cnt_reg;
        pad_active_next = pad_active_reg;
        mark_done_next  = mark_done_reg;
        len_phase_next  = len_phase_reg;

        if (in_fire && !no_byte)
        begin
            len_next = len_reg + 64'd8;
        end
        if (in_fire && is_last)
        begin
            pad_active_next = 1'b1;
        end
        if (state_reg == ST_PAD)
        begin
            mark_done_next = 1'b1;
            if (pad_is_len)
            begin
                len_phase_next = 1'b1;
            end
        end

        // byte packing, big-endian, a full word shifts into the window
        if (put_en)
        begin
            acc_next  = {acc_reg[15:0], put_data};
            fill_next = fill_reg + 6'd1;
            if (fill_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < WINDOW_WORDS - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[WINDOW_WORDS - 1] = {acc_reg, put_data};
            end
        end
        if (block_done)
        begin
            round_next = chain_reg;
        end

        if (state_reg == ST_COMPRESS)
        begin
            rnd_next = rnd_reg + 6'd1;
            for (int i = 0; i < WINDOW_WORDS - 1; i++)
            begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[WINDOW_WORDS - 1] = sched_new;
            round_next[7] = round_reg[6];
            round_next[6] = round_reg[5];
            round_next[5] = round_reg[4];
            round_next[4] = round_reg[3] + t1;
            round_next[3] = round_reg[2];
            round_next[2] = round_reg[1];
            round_next[1] = round_reg[0];
            round_next[0] = t1 + t2;
        end

        if (state_reg == ST_ADD)
        begin
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                chain_next[i] = chain_reg[i] + round_reg[i];
            end
        end

        if ((state_reg == ST_OUT) && out_fire)
        begin
            out_cnt_next = out_cnt_reg + 3'd1;
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                chain_next[i] = chain_reg[i + 1];
            end
            chain_next[CHAIN_WORDS - 1] = chain_reg[0];
            if (out_cnt_reg == WORD_LAST)
            begin
                // message done, back to a fresh hash
                chain_next      = INIT_H;
                for (int i = 0; i < CHAIN_WORDS; i++)
                begin
                    round_next[i] = 32'd0;
                end
                len_next        = 64'd0;
                fill_next       = 6'd0;
                out_cnt_next    = 3'd0;
                pad_active_next = 1'b0;
                mark_done_next  = 1'b0;
                len_phase_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            chain_reg      <= INIT_H;
            for (int i = 0; i < CHAIN_WORDS; i++)
            begin
                round_reg[i] <= 32'd0;
            end
            len_reg        <= 64'd0;
            fill_reg       <= 6'd0;
            rnd_reg        <= 6'd0;
            out_cnt_reg    <= 3'd0;
            pad_active_reg <= 1'b0;
            mark_done_reg  <= 1'b0;
            len_phase_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chain_reg      <= chain_next;
            round_reg      <= round_next;
            len_reg        <= len_next;
            fill_reg       <= fill_next;
            rnd_reg        <= rnd_next;
            out_cnt_reg    <= out_cnt_next;
            pad_active_reg <= pad_active_next;
            mark_done_reg  <= mark_done_next;
            len_phase_reg  <= len_phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        acc_reg <= acc_next;
    end

    `SBSH_ASSERT_NOW(a_no_out_while_ready, out_valid, !in_ready, "digest shown while taking input")
    `SBSH_ASSERT_NOW(a_round_idle_zero, state_reg != ST_COMPRESS, rnd_reg == 6'd0,
        "round counter off zero outside compression")
    `SBSH_ASSERT_NEXT(a_last_round_adds, (state_reg == ST_COMPRESS) && (rnd_reg == ROUND_LAST),
        state_reg == ST_ADD, "chain add did not follow the last round")
    `SBSH_ASSERT_NEXT(a_final_word_idle, out_fire && final_word,
        in_ready && (fill_reg == 6'd0) && (len_reg == 64'd0), "hasher not fresh after digest")
    `SBSH_ASSERT_NOW(a_len_after_mark, len_phase_reg, mark_done_reg && pad_active_reg,
        "length bytes without padding marker")

endmodule
